// ----- hdl/rgblp_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB LED PWM frame generator package
// Item types, operation and result codes, and the brightness step table.
// ----------------------------------------------------------------------------
package rgblp_pkg;

    localparam int OP_W     = 3;
    localparam int SEL_W    = 8;
    localparam int RGB_W    = 24;
    localparam int PCT_IN_W = 16;
    localparam int KIND_W   = 2;
    localparam int WORD_W   = 16;
    localparam int CMP_W    = 8;
    localparam int BRIGHT_W = 7;
    localparam int COMP_W   = 8;
    localparam int STEP_W   = 3;

    localparam logic [OP_W-1:0] OP_COLOUR = 3'd0;
    localparam logic [OP_W-1:0] OP_MODE   = 3'd1;
    localparam logic [OP_W-1:0] OP_ON     = 3'd2;
    localparam logic [OP_W-1:0] OP_FRAME  = 3'd3;
    localparam logic [OP_W-1:0] OP_SET    = 3'd4;
    localparam logic [OP_W-1:0] OP_STEP   = 3'd5;

    localparam logic [KIND_W-1:0] KIND_RED    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GREEN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BLUE   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BRIGHT = 2'd3;

    localparam logic [RGB_W-1:0]    COLOUR_RESET   = 24'hFFFFFF;
    localparam logic [BRIGHT_W-1:0] MAX_PERCENT    = 7'd100;
    localparam logic [CMP_W-1:0]    CMP_MAX        = 8'hFF;
    localparam int                  LED_BIT_OFFSET = 2;
    localparam int                  STEP_RESET     = 1;

    // Division by 100 of a product below 256*100 is a multiply by the
    // reciprocal 5243/2^19, exact over that range.
    localparam int SAT_PRODUCT = 256 * 100;
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_IN_W  = 15;
    localparam int RECIP_OUT_W = 28;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [SEL_W-1:0]    led_select;
        logic [RGB_W-1:0]    rgb_value;
        logic                user_mode;
        logic                led_on;
        logic [PCT_IN_W-1:0] percent_in;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [WORD_W-1:0]   shift_word;
        logic                latch_pulse;
        logic [CMP_W-1:0]    pwm_compare;
        logic [BRIGHT_W-1:0] brightness_now;
    } t_out_item;

    typedef struct packed {
        logic                set;
        logic                step;
        logic [PCT_IN_W-1:0] percent;
    } t_bright_cmd;

    typedef struct packed {
        logic [BRIGHT_W-1:0] brightness;
        logic [CMP_W-1:0]    compare;
    } t_bright_stat;

    function automatic logic [BRIGHT_W-1:0] step_level(input logic [STEP_W-1:0] idx);
        logic [BRIGHT_W-1:0] v;
        unique case (idx)
            3'd0: v = 7'd100;
            3'd1: v = 7'd70;
            3'd2: v = 7'd40;
            3'd3: v = 7'd25;
            3'd4: v = 7'd12;
            3'd5: v = 7'd5;
            3'd6: v = 7'd1;
            3'd7: v = 7'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/rgblp_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module rgblp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 24,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/rgblp_bright.sv -----
// ----------------------------------------------------------------------------
// Brightness unit
// Holds brightness, compare value and step index; computes the compare value
// in two registered steps.
// ----------------------------------------------------------------------------
module rgblp_bright
    import rgblp_pkg::*;
#(
    parameter int PWM_PERIOD = 255
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_bright_cmd  i_cmd,
    output t_bright_stat o_stat
);

    localparam int PERIOD_W = $clog2(PWM_PERIOD + 1);
    localparam int PROD_W   = BRIGHT_W + PERIOD_W;

    logic [BRIGHT_W-1:0] r_bright;
    logic [CMP_W-1:0]    r_cmp;
    logic [STEP_W-1:0]   r_step;
    logic [PROD_W-1:0]   r_prod;
    logic                r_phase;

    logic [BRIGHT_W-1:0]    n_pct;
    logic [31:0]            n_prod_ext;
    logic [RECIP_OUT_W-1:0] n_recip;
    logic [CMP_W-1:0]       n_cmp;

    always_comb begin
        if (i_cmd.step) begin
            n_pct = step_level(r_step);
        end else if (i_cmd.percent > PCT_IN_W'(MAX_PERCENT)) begin
            n_pct = MAX_PERCENT;
        end else begin
            n_pct = i_cmd.percent[BRIGHT_W-1:0];
        end
    end

    always_comb begin
        n_prod_ext = 32'(r_prod);
        n_recip    = RECIP_OUT_W'(n_prod_ext[RECIP_IN_W-1:0]) * RECIP_OUT_W'(RECIP_100);
        if (n_prod_ext >= 32'(SAT_PRODUCT)) begin
            n_cmp = CMP_MAX;
        end else begin
            n_cmp = n_recip[RECIP_SHIFT +: CMP_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= MAX_PERCENT;
            r_cmp    <= CMP_MAX;
            r_step   <= STEP_W'(STEP_RESET);
            r_phase  <= 1'b0;
        end else begin
            r_phase <= i_cmd.set || i_cmd.step;
            if (i_cmd.set || i_cmd.step) begin
                r_bright <= n_pct;
                r_prod   <= PROD_W'(n_pct) * PROD_W'(PWM_PERIOD);
            end
            if (i_cmd.step) begin
                r_step <= r_step + 1'b1;
            end
            if (r_phase) begin
                r_cmp <= n_cmp;
            end
        end
    end

    assign o_stat.brightness = r_bright;
    assign o_stat.compare    = r_cmp;

endmodule

// ----- hdl/rgblp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Frame sequencer
// Decodes items, sweeps the colour memory for writes and frames, keeps the
// mode and on bits, and holds the result register.
// ----------------------------------------------------------------------------
module rgblp_ctrl
    import rgblp_pkg::*;
#(
    parameter int NUM_LEDS   = 12,
    parameter int LEVEL_BITS = 4,
    parameter int AW         = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item,
    output logic             o_ram_we,
    output logic [AW-1:0]    o_ram_waddr,
    output logic [RGB_W-1:0] o_ram_wdata,
    output logic [AW-1:0]    o_ram_raddr,
    input  logic [RGB_W-1:0] i_ram_rdata,
    output t_bright_cmd      o_bcmd,
    input  t_bright_stat     i_bstat
);

    localparam int LED_W   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int DEPTH   = 2 * NUM_LEDS;
    localparam int SHIFT_W = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WR_ALL,
        S_FRAME,
        S_EMIT,
        S_BR_WAIT,
        S_BR_EMIT
    } t_state;

    t_state              r_state;
    t_in_item            r_item;
    logic [LED_W-1:0]    r_idx;
    logic                r_issue_done;
    logic                r_pend;
    logic [LED_W-1:0]    r_pend_led;
    logic                r_pend_valid;
    logic [WORD_W-1:0]   r_red;
    logic [WORD_W-1:0]   r_grn;
    logic [WORD_W-1:0]   r_blu;
    logic [1:0]          r_emit;
    logic [LEVEL_BITS-1:0] r_level;
    logic [NUM_LEDS-1:0] r_mode;
    logic [NUM_LEDS-1:0] r_don;
    logic [NUM_LEDS-1:0] r_uon;
    logic [DEPTH-1:0]    r_cvalid;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                n_accept;
    logic                n_all;
    logic [LED_W-1:0]    n_sel;
    logic                n_can_load;
    logic                n_load;
    logic [AW-1:0]       n_rd_addr;
    logic [RGB_W-1:0]    n_colour;
    logic                n_on;
    logic [COMP_W-1:0]   n_thr;
    logic [SHIFT_W-1:0]  n_pos;
    logic [KIND_W-1:0]   n_kind;
    logic [WORD_W-1:0]   n_word;

    function automatic logic [AW-1:0] addr_of(input logic [LED_W-1:0] led, input logic user);
        return user ? (AW'(NUM_LEDS) + AW'(led)) : AW'(led);
    endfunction

    assign o_in_stall  = (r_state != S_IDLE);
    assign n_accept    = i_in_valid && (r_state == S_IDLE);
    assign n_all       = (i_in_item.led_select >= SEL_W'(NUM_LEDS));
    assign n_sel       = i_in_item.led_select[LED_W-1:0];
    assign n_can_load  = !r_out_valid || !i_out_stall;
    assign n_load      = n_can_load && (r_state == S_EMIT || r_state == S_BR_EMIT);
    assign n_rd_addr   = addr_of(r_idx, r_mode[r_idx]);

    // Colour memory ports: a single write goes straight from the input item,
    // a broadcast write sweeps one LED per cycle in its current bank.
    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = addr_of(n_sel, r_mode[n_sel]);
        o_ram_wdata = i_in_item.rgb_value;
        if (r_state == S_WR_ALL) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = n_rd_addr;
            o_ram_wdata = r_item.rgb_value;
        end else if (n_accept && i_in_item.op == OP_COLOUR && !n_all) begin
            o_ram_we = 1'b1;
        end
    end
    assign o_ram_raddr = n_rd_addr;

    assign o_bcmd.set     = n_accept && (i_in_item.op == OP_SET);
    assign o_bcmd.step    = n_accept && (i_in_item.op == OP_STEP);
    assign o_bcmd.percent = i_in_item.percent_in;

    // Per-LED evaluation of the entry read in the previous cycle.
    assign n_colour = r_pend_valid ? i_ram_rdata : COLOUR_RESET;
    assign n_on     = r_mode[r_pend_led] ? r_uon[r_pend_led] : r_don[r_pend_led];
    assign n_thr    = COMP_W'(r_level) << (COMP_W - LEVEL_BITS);
    assign n_pos    = SHIFT_W'(LED_BIT_OFFSET) + SHIFT_W'(r_pend_led);

    always_comb begin
        unique case (r_emit)
            2'd0:    begin n_kind = KIND_RED;   n_word = r_red; end
            2'd1:    begin n_kind = KIND_GREEN; n_word = r_grn; end
            default: begin n_kind = KIND_BLUE;  n_word = r_blu; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_level     <= '0;
            r_mode      <= '0;
            r_don       <= '0;
            r_uon       <= '1;
            r_cvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !n_load) begin
                r_out_valid <= 1'b0;
            end
            if (o_ram_we) begin
                r_cvalid[o_ram_waddr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_item       <= i_in_item;
                        r_idx        <= '0;
                        r_issue_done <= 1'b0;
                        r_pend       <= 1'b0;
                        r_red        <= '0;
                        r_grn        <= '0;
                        r_blu        <= '0;
                        r_emit       <= '0;
                        for (int i = 0; i < NUM_LEDS; i++) begin
                            if (n_all || n_sel == LED_W'(i)) begin
                                if (i_in_item.op == OP_MODE) begin
                                    r_mode[i] <= i_in_item.user_mode;
                                end else if (i_in_item.op == OP_ON) begin
                                    if (r_mode[i]) begin
                                        r_uon[i] <= i_in_item.led_on;
                                    end else begin
                                        r_don[i] <= i_in_item.led_on;
                                    end
                                end
                            end
                        end
                        if (i_in_item.op == OP_COLOUR && n_all) begin
                            r_state <= S_WR_ALL;
                        end else if (i_in_item.op == OP_FRAME) begin
                            r_state <= S_FRAME;
                        end else if (i_in_item.op == OP_SET || i_in_item.op == OP_STEP) begin
                            r_state <= S_BR_WAIT;
                        end
                    end
                end
                S_WR_ALL: begin
                    if (r_idx == LED_W'(NUM_LEDS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_FRAME: begin
                    if (!r_issue_done) begin
                        r_pend       <= 1'b1;
                        r_pend_led   <= r_idx;
                        r_pend_valid <= r_cvalid[n_rd_addr];
                        if (r_idx == LED_W'(NUM_LEDS - 1)) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        r_red <= r_red | (WORD_W'(n_on && (n_colour[23:16] > n_thr)) << n_pos);
                        r_grn <= r_grn | (WORD_W'(n_on && (n_colour[15:8] > n_thr)) << n_pos);
                        r_blu <= r_blu | (WORD_W'(n_on && (n_colour[7:0] > n_thr)) << n_pos);
                        if (r_pend_led == LED_W'(NUM_LEDS - 1)) begin
                            r_level <= r_level + 1'b1;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (n_can_load) begin
                        r_out_valid          <= 1'b1;
                        r_out.kind           <= n_kind;
                        r_out.shift_word     <= n_word;
                        r_out.latch_pulse    <= (n_kind == KIND_BLUE);
                        r_out.pwm_compare    <= i_bstat.compare;
                        r_out.brightness_now <= i_bstat.brightness;
                        r_emit               <= r_emit + 1'b1;
                        if (n_kind == KIND_BLUE) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_BR_WAIT: begin
                    r_state <= S_BR_EMIT;
                end
                S_BR_EMIT: begin
                    if (n_can_load) begin
                        r_out_valid          <= 1'b1;
                        r_out.kind           <= KIND_BRIGHT;
                        r_out.shift_word     <= '0;
                        r_out.latch_pulse    <= 1'b0;
                        r_out.pwm_compare    <= i_bstat.compare;
                        r_out.brightness_now <= i_bstat.brightness;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- hdl/rgb_led_pwm_frame_generator_core.sv -----
// ----------------------------------------------------------------------------
// RGB LED PWM frame generator core
// Keeps colour, mode and on state of a row of RGB LEDs and emits the shift
// words of one software PWM frame per tick, plus brightness updates.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the input channel (i_in_valid, o_in_stall, i_in_item) and
// results leave on the output channel (o_out_valid, i_out_stall, o_out_item).
// An item is taken at a clock edge where valid is high and stall is low.
// Both sides are parted by a result register, so an item can be taken while
// an earlier result still waits for the receiver.
// A single-LED colour, mode or on write is done as the item is taken. A
// colour write to all LEDs sweeps the colour memory, one LED per cycle.
// A frame tick reads every LED's colour from the memory in turn (one read a
// cycle through its single read port), then the red, green and blue words
// are loaded in order into the result register. Brightness set and step
// wait for the two-step compare calculation before their result is loaded.
// When the receiver stalls, the result register holds and the sequencer
// waits; input stays stalled until the item's results are all loaded.
// Reset is synchronous and active low; it restores white colours, default
// mode, the on bits, level zero and full brightness at once.
// ----------------------------------------------------------------------------
module rgb_led_pwm_frame_generator_core
    import rgblp_pkg::*;
#(
    parameter int NUM_LEDS   = 12,
    parameter int LEVEL_BITS = 4,
    parameter int PWM_PERIOD = 255
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // Colour memory: entry i is the default bank of LED i, entry NUM_LEDS+i
    // its user bank.
    localparam int DEPTH = 2 * NUM_LEDS;
    localparam int AW    = $clog2(DEPTH);

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [RGB_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [RGB_W-1:0] ram_rdata;
    t_bright_cmd      bcmd;
    t_bright_stat     bstat;

    rgblp_ctrl #(
        .NUM_LEDS   (NUM_LEDS),
        .LEVEL_BITS (LEVEL_BITS),
        .AW         (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_bcmd      (bcmd),
        .i_bstat     (bstat)
    );

    rgblp_ram #(
        .WIDTH (RGB_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_colour_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rgblp_bright #(
        .PWM_PERIOD (PWM_PERIOD)
    ) u_bright (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (bcmd),
        .o_stat  (bstat)
    );

endmodule

// ----- hdl/rgblp_checker.sv -----
// ----------------------------------------------------------------------------
// RGB LED PWM frame generator checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
module rgblp_checker
    import rgblp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // The latch pulse marks the blue word only.
    a_latch_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.latch_pulse |-> o_out_item.kind == KIND_BLUE)
        else $error("latch pulse on a word other than blue");

    // A brightness item carries no LED bits and no latch.
    a_bright_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_BRIGHT
        |-> o_out_item.shift_word == '0 && !o_out_item.latch_pulse)
        else $error("brightness item with shift bits or latch");

    // Brightness never exceeds the clamp.
    a_bright_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.brightness_now <= MAX_PERCENT)
        else $error("brightness above clamp");

    // Once the red word is taken, green and blue are still to come, so the
    // input must stay closed.
    a_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_item.kind == KIND_RED |=> o_in_stall)
        else $error("input opened in the middle of a frame");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

endmodule

bind rgb_led_pwm_frame_generator_core rgblp_checker u_checker (.*);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// RGB LED PWM frame generator testbench
// Drives operation items into the core, predicts every shift word and
// brightness update it should return, and compares them field by field.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rgblp_pkg::*;

    localparam int NUM_LEDS   = 12;
    localparam int LEVEL_BITS = 4;
    localparam int PWM_PERIOD = 255;

    // Op codes the core takes and ignores.
    localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

    // Brightness percentages visited by the step operation, in order.
    localparam logic [BRIGHT_W-1:0] STEP_PCT [8] = '{
        7'd100, 7'd70, 7'd40, 7'd25, 7'd12, 7'd5, 7'd1, 7'd0
    };

    // The receiver hold used to back the core up into its input.
    localparam int LONG_HOLD_CYCLES = 300;
    // This spans more than a whole frame, so it covers any late word.
    localparam int DRAIN_CYCLES     = 4 * NUM_LEDS;
    // Quiet cycles allowed before the run is declared hung. The longest
    // legal quiet stretch is the long receiver hold plus one frame.
    localparam int WATCHDOG_LIMIT   = 2000;

    // ------------------------------------------------------------------------
    // Scoreboard: a private copy of the LED banks, the level counter and the
    // brightness state. Each accepted item updates that copy and queues the
    // words the core must return; each returned word is checked in order.
    // ------------------------------------------------------------------------
    class frame_word_scoreboard;
        logic [RGB_W-1:0]      colour_bank [2*NUM_LEDS];
        logic                  in_user_mode [NUM_LEDS];
        logic                  default_lit [NUM_LEDS];
        logic                  user_lit [NUM_LEDS];
        logic [LEVEL_BITS-1:0] frame_level;
        logic [BRIGHT_W-1:0]   brightness;
        logic [CMP_W-1:0]      compare_value;
        logic [STEP_W-1:0]     step_pos;
        t_out_item             expected_words [$];
        int unsigned           mismatches;

        function new();
            for (int i = 0; i < 2*NUM_LEDS; i++) begin
                colour_bank[i] = COLOUR_RESET;
            end
            for (int i = 0; i < NUM_LEDS; i++) begin
                in_user_mode[i] = 1'b0;
                default_lit[i]  = 1'b0;
                user_lit[i]     = 1'b1;
            end
            frame_level = '0;
            step_pos    = STEP_W'(STEP_RESET);
            mismatches  = 0;
            apply_brightness(MAX_PERCENT);
        endfunction

        function void apply_brightness(int unsigned pct);
            int unsigned scaled;
            if (pct > MAX_PERCENT) begin
                pct = MAX_PERCENT;
            end
            scaled        = pct * PWM_PERIOD / MAX_PERCENT;
            brightness    = BRIGHT_W'(pct);
            compare_value = (scaled > CMP_MAX) ? CMP_MAX : CMP_W'(scaled);
        endfunction

        // Colour and on-state writes land in the bank of the LED's present mode.
        function void write_led(int idx, t_in_item it);
            int bank;
            bank = in_user_mode[idx] ? NUM_LEDS + idx : idx;
            case (it.op)
                OP_COLOUR: colour_bank[bank] = it.rgb_value;
                OP_MODE:   in_user_mode[idx] = it.user_mode;
                default: begin
                    if (in_user_mode[idx]) begin
                        user_lit[idx] = it.led_on;
                    end else begin
                        default_lit[idx] = it.led_on;
                    end
                end
            endcase
        endfunction

        function logic [WORD_W-1:0] channel_word(int lsb, logic [7:0] thr);
            logic [WORD_W-1:0] word;
            logic [7:0]        comp;
            logic              lit;
            int                bank;
            word = '0;
            for (int i = 0; i < NUM_LEDS; i++) begin
                bank = in_user_mode[i] ? NUM_LEDS + i : i;
                lit  = in_user_mode[i] ? user_lit[i] : default_lit[i];
                comp = 8'(colour_bank[bank] >> lsb);
                if (lit && comp > thr) begin
                    word[LED_BIT_OFFSET + i] = 1'b1;
                end
            end
            return word;
        endfunction

        function void push_result(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] word,
                                  logic latch);
            t_out_item r;
            r.kind           = kind;
            r.shift_word     = word;
            r.latch_pulse    = latch;
            r.pwm_compare    = compare_value;
            r.brightness_now = brightness;
            expected_words.push_back(r);
        endfunction

        function void note_input(t_in_item it);
            logic [7:0] thr;
            case (it.op)
                OP_COLOUR, OP_MODE, OP_ON: begin
                    if (it.led_select >= NUM_LEDS) begin
                        for (int i = 0; i < NUM_LEDS; i++) begin
                            write_led(i, it);
                        end
                    end else begin
                        write_led(int'(it.led_select), it);
                    end
                end
                OP_FRAME: begin
                    thr = 8'(frame_level) << (8 - LEVEL_BITS);
                    push_result(KIND_RED,   channel_word(16, thr), 1'b0);
                    push_result(KIND_GREEN, channel_word(8, thr),  1'b0);
                    push_result(KIND_BLUE,  channel_word(0, thr),  1'b1);
                    frame_level = frame_level + 1'b1;
                end
                OP_SET: begin
                    apply_brightness(it.percent_in);
                    push_result(KIND_BRIGHT, '0, 1'b0);
                end
                OP_STEP: begin
                    apply_brightness(STEP_PCT[step_pos]);
                    step_pos = step_pos + 1'b1;
                    push_result(KIND_BRIGHT, '0, 1'b0);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_words.size() == 0) begin
                $error("result with no item pending: %p", got);
                mismatches++;
                return;
            end
            want = expected_words.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                mismatches++;
            end
            if (got.shift_word !== want.shift_word) begin
                $error("shift_word: expected 0x%04h, got 0x%04h",
                       want.shift_word, got.shift_word);
                mismatches++;
            end
            if (got.latch_pulse !== want.latch_pulse) begin
                $error("latch_pulse: expected %0d, got %0d",
                       want.latch_pulse, got.latch_pulse);
                mismatches++;
            end
            if (got.pwm_compare !== want.pwm_compare) begin
                $error("pwm_compare: expected %0d, got %0d",
                       want.pwm_compare, got.pwm_compare);
                mismatches++;
            end
            if (got.brightness_now !== want.brightness_now) begin
                $error("brightness_now: expected %0d, got %0d",
                       want.brightness_now, got.brightness_now);
                mismatches++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    frame_word_scoreboard frame_sb;

    // Idling switches for the two sides, and the request for one long hold.
    bit          tx_idling;
    bit          rx_idling;
    bit          long_hold_req;
    int unsigned quiet_cycles;

    rgb_led_pwm_frame_generator_core #(
        .NUM_LEDS   (NUM_LEDS),
        .LEVEL_BITS (LEVEL_BITS),
        .PWM_PERIOD (PWM_PERIOD)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly back to back, sometimes a short gap, now and then a long pause.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Both handshakes are sampled at the rising edge, where the core's own
    // outputs still hold their values from before the edge. Inputs are only
    // changed at the falling edge, so nothing here depends on event order.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            frame_sb.note_input(i_in_item);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            frame_sb.check_result(o_out_item);
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver. When idling is on, it stalls for random stretches. A long
    // hold request is served here, counted in this process, while the main
    // sequence keeps offering items so that the core backs up.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (rx_idling && $urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                repeat (pick_gap() + 1) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Offers one item and holds it until the core takes it. Valid stays high
    // into the next item when no gap follows, so it is never dropped and
    // raised within one time step.
    task automatic send_item(input t_in_item it);
        int unsigned gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        gap = tx_idling ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic t_in_item make_item(logic [OP_W-1:0] op, logic [SEL_W-1:0] sel,
                                           logic [RGB_W-1:0] rgb, logic mode, logic on,
                                           logic [PCT_IN_W-1:0] pct);
        t_in_item it;
        it.op         = op;
        it.led_select = sel;
        it.rgb_value  = rgb;
        it.user_mode  = mode;
        it.led_on     = on;
        it.percent_in = pct;
        return it;
    endfunction

    // Components cluster on the extremes and on both sides of the level
    // thresholds, since the compare there is strict.
    function automatic logic [7:0] pick_component();
        logic [7:0] edge_val;
        case ($urandom_range(0, 4))
            0: return 8'h00;
            1: return 8'hFF;
            2: begin
                edge_val = 8'($urandom_range(0, 15)) << (8 - LEVEL_BITS);
                return edge_val + 8'($urandom_range(0, 1));
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned r;
        // Every field is randomized; the op decides which ones matter.
        it.rgb_value  = {pick_component(), pick_component(), pick_component()};
        it.user_mode  = 1'($urandom_range(0, 1));
        it.led_on     = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 9);
        if (r < 7) begin
            it.led_select = SEL_W'($urandom_range(0, NUM_LEDS - 1));
        end else if (r == 7) begin
            it.led_select = SEL_W'($urandom_range(NUM_LEDS, NUM_LEDS + 3));
        end else if (r == 8) begin
            it.led_select = '1;
        end else begin
            it.led_select = SEL_W'($urandom_range(0, 255));
        end
        r = $urandom_range(0, 3);
        if (r == 0) begin
            it.percent_in = PCT_IN_W'($urandom_range(0, 65535));
        end else if (r == 1) begin
            it.percent_in = PCT_IN_W'($urandom_range(101, 300));
        end else begin
            it.percent_in = PCT_IN_W'($urandom_range(0, 100));
        end
        r = $urandom_range(0, 99);
        if (r < 30) begin
            it.op = OP_FRAME;
        end else if (r < 55) begin
            it.op = OP_COLOUR;
        end else if (r < 65) begin
            it.op = OP_MODE;
        end else if (r < 80) begin
            it.op = OP_ON;
        end else if (r < 88) begin
            it.op = OP_SET;
        end else if (r < 95) begin
            it.op = OP_STEP;
        end else begin
            it.op = r[0] ? OP_RSVD_LO : OP_RSVD_HI;
        end
        return it;
    endfunction

    // Sends random items until the given number of meaningful ones has gone
    // in; the ignored op codes ride along without counting.
    task automatic send_random(input int unsigned count);
        t_in_item    it;
        int unsigned taken;
        taken = 0;
        while (taken < count) begin
            it = random_item();
            send_item(it);
            if (it.op != OP_RSVD_LO && it.op != OP_RSVD_HI) begin
                taken++;
            end
        end
    endtask

    task automatic send_directed();
        // A frame right after reset: every LED is off in default mode.
        send_item(make_item(OP_FRAME, 8'd0, '0, 1'b0, 1'b0, '0));
        // Turn everything on, then a frame of white LEDs over the threshold.
        send_item(make_item(OP_ON, 8'd255, '0, 1'b0, 1'b1, '0));
        send_item(make_item(OP_FRAME, 8'd0, '0, 1'b0, 1'b0, '0));
        // Colour write to all LEDs, then single LEDs at both ends of the row.
        // LED 11 sits exactly on the next threshold in green and just below
        // it in blue.
        send_item(make_item(OP_COLOUR, 8'(NUM_LEDS), 24'h80F00F, 1'b0, 1'b0, '0));
        send_item(make_item(OP_COLOUR, 8'd0, 24'h000000, 1'b0, 1'b0, '0));
        send_item(make_item(OP_COLOUR, 8'(NUM_LEDS - 1), 24'h21201F, 1'b0, 1'b0, '0));
        // LED 5 moves to its user bank and is switched off there.
        send_item(make_item(OP_MODE, 8'd5, '0, 1'b1, 1'b0, '0));
        send_item(make_item(OP_ON, 8'd5, '0, 1'b0, 1'b0, '0));
        send_item(make_item(OP_FRAME, 8'd0, '0, 1'b0, 1'b0, '0));
        // Everything to user mode; the user bank still holds white.
        send_item(make_item(OP_MODE, 8'd200, '0, 1'b1, 1'b0, '0));
        send_item(make_item(OP_COLOUR, 8'd3, 24'hFFFFFF, 1'b0, 1'b0, '0));
        send_item(make_item(OP_FRAME, 8'd0, '0, 1'b0, 1'b0, '0));
        // The unused op codes return nothing, whatever their fields hold.
        send_item(make_item(OP_RSVD_LO, 8'd255, 24'hFFFFFF, 1'b1, 1'b1, 16'hFFFF));
        send_item(make_item(OP_RSVD_HI, 8'd0, 24'hA5A5A5, 1'b1, 1'b1, 16'd50));
        // Brightness set at zero, at the clamp and past it, and in between.
        send_item(make_item(OP_SET, 8'd0, '0, 1'b0, 1'b0, 16'd0));
        send_item(make_item(OP_SET, 8'd0, '0, 1'b0, 1'b0, 16'd100));
        send_item(make_item(OP_SET, 8'd0, '0, 1'b0, 1'b0, 16'd101));
        send_item(make_item(OP_SET, 8'd0, '0, 1'b0, 1'b0, 16'hFFFF));
        send_item(make_item(OP_SET, 8'd0, '0, 1'b0, 1'b0, 16'd50));
        // Eight steps walk the whole table and wrap its index.
        repeat (8) send_item(make_item(OP_STEP, 8'd0, '0, 1'b0, 1'b0, '0));
    endtask

    initial begin
        frame_sb      = new();
        quiet_cycles  = 0;
        tx_idling     = 1'b0;
        rx_idling     = 1'b0;
        long_hold_req = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_item     = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idling = 1'b1;
        rx_idling = 1'b1;
        send_directed();
        send_random(110);

        // A stretch at full rate on both sides.
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        send_random(50);

        // The receiver holds off for a long time while frames keep coming,
        // so the result register fills and the core stalls its input.
        long_hold_req = 1'b1;
        repeat (40) send_item(make_item(OP_FRAME, 8'd0, '0, 1'b0, 1'b0, '0));

        tx_idling = 1'b1;
        rx_idling = 1'b1;
        send_random(140);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        rx_idling = 1'b0;
        while (frame_sb.expected_words.size() != 0) @(posedge i_clk);
        // Any word past the last expected one is caught as unexpected here.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (frame_sb.mismatches == 0 && frame_sb.expected_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/rgblp_pkg.sv
hdl/rgblp_ram.sv
hdl/rgblp_bright.sv
hdl/rgblp_ctrl.sv
hdl/rgb_led_pwm_frame_generator_core.sv
hdl/rgblp_checker.sv
tb/tb.sv
